// ----- rtl/core/pcff_pkg.sv -----
// shared constants and types for the power-of-two coefficient fir filter
package pcff_pkg;

  localparam int TAPS_DEF   = 256;
  localparam int POWERS_DEF = 16;

  localparam int SAMPLE_W = 16;
  localparam int COEFF_W  = 32;
  localparam int INDEX_W  = 8;
  localparam int ACC_W    = 40;

  // input word kinds
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_FILTER = 1'b1;

  // control from the sequencer to the bit-serial tap unit
  typedef struct packed {
    logic clear;
    logic load;
    logic step;
  } mac_ctl_t;

endpackage

// ----- rtl/core/pot_coefficient_fir_filter_top.sv -----
// top level of the power-of-two coefficient fir filter
//
// fir filter whose taps are signed sums of powers of two. an input word with
// mode 0 writes coeff_word into slot tap_index (slots at or beyond TAPS are
// dropped) and gives no output. an input word with mode 1 pushes sample into
// the history (all zero after reset) and gives one output word, the sum over
// every tap of +/- (x << 16) >> j for each selected power, wrapped to 40 bits.
// coefficients and history live in two rams; the history is a circular
// buffer with a fill count, so slots not yet filled since reset read as zero
// without any clearing pass. coefficient slots must be written before the
// first sample. one ram read per tap feeds a bit-serial unit that steps through
// the powers one at a time; no new word is taken until a sample's sweep over
// all taps is done, while a coefficient load leaves the block idle. the
// output sits in a register, so the next word is taken while a result still
// waits for out_ready.
module pot_coefficient_fir_filter_top import pcff_pkg::*; #(
  parameter int TAPS   = TAPS_DEF,
  parameter int POWERS = POWERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       mode,
  input  logic [INDEX_W-1:0]         tap_index,
  input  logic [COEFF_W-1:0]         coeff_word,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [ACC_W-1:0]    filtered_out
);

  localparam int AW  = TAPS > 1 ? $clog2(TAPS) : 1;    // ram address
  localparam int FW  = $clog2(TAPS + 1);               // fill count 0..TAPS
  localparam int PCW = POWERS > 1 ? $clog2(POWERS) : 1; // power counter

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_LOAD,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t           state;
  logic [AW-1:0]    wp;        // slot of the newest sample
  logic [AW-1:0]    wp_next;
  logic [FW-1:0]    fill;      // samples pushed since reset, saturating
  logic [AW-1:0]    k;         // tap whose data sits in the ram outputs
  logic [AW-1:0]    haddr;     // history slot of tap k
  logic [PCW-1:0]   pc;        // powers left after the current one in this tap
  logic             last;      // current tap is the final one

  logic             accept;
  logic             coeff_we;
  logic             hist_we;
  logic [COEFF_W-1:0]         coeff_rdata;
  logic [SAMPLE_W-1:0]        hist_rdata;
  logic signed [SAMPLE_W-1:0] tap_x;
  logic signed [ACC_W-1:0]    acc;
  mac_ctl_t                   mac_ctl;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign coeff_we = accept && (mode == MODE_LOAD) && (32'(tap_index) < 32'(TAPS));
  assign hist_we  = accept && (mode == MODE_FILTER);

  // circular history: next slot with wrap at TAPS
  assign wp_next = (wp == AW'(TAPS - 1)) ? '0 : wp + AW'(1);

  // slots never filled since reset count as zero samples
  assign tap_x = (FW'(k) < fill) ? signed'(hist_rdata) : '0;

  always_comb begin
    mac_ctl.clear = hist_we;
    mac_ctl.load  = (state == S_LOAD);
    mac_ctl.step  = (state == S_SHIFT);
  end

  pcff_ram #(
    .WIDTH (COEFF_W),
    .DEPTH (TAPS)
  ) u_coeff_ram (
    .clk   (clk),
    .we    (coeff_we),
    .waddr (AW'(tap_index)),
    .wdata (coeff_word),
    .raddr (k),
    .rdata (coeff_rdata)
  );

  pcff_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TAPS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (wp_next),
    .wdata (sample),
    .raddr (haddr),
    .rdata (hist_rdata)
  );

  pcff_tap_mac #(
    .POWERS (POWERS)
  ) u_tap_mac (
    .clk   (clk),
    .ctl   (mac_ctl),
    .x     (tap_x),
    .coeff (coeff_rdata),
    .acc   (acc)
  );

  // sequencer: per tap a load state, then the shift state once for each power
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      wp        <= '0;
      fill      <= '0;
    end else begin
      // in S_DONE the output register is handled by the state itself
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (hist_we) begin
            wp    <= wp_next;
            haddr <= wp_next;
            k     <= '0;
            if (fill != FW'(TAPS)) begin
              fill <= fill + FW'(1);
            end
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          // ram outputs for tap 0 are ready next cycle
          state <= S_LOAD;
        end
        S_LOAD: begin
          pc   <= PCW'(POWERS - 1);
          last <= (k == AW'(TAPS - 1));
          if (k != AW'(TAPS - 1)) begin
            // prefetch the next tap while this one shifts
            k     <= k + AW'(1);
            haddr <= (haddr == '0) ? AW'(TAPS - 1) : haddr - AW'(1);
          end
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          if (pc == '0) begin
            state <= last ? S_DONE : S_LOAD;
          end else begin
            pc <= pc - PCW'(1);
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            filtered_out <= acc;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(TAPS))
    else $error("history fill count beyond tap count");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    hist_we |=> (fill == FW'(TAPS)) || (fill == $past(fill) + FW'(1)))
    else $error("fill count did not advance on a pushed sample");

  a_load_then_shift: assert property (@(posedge clk) disable iff (rst)
    mac_ctl.load |=> mac_ctl.step && !mac_ctl.load)
    else $error("tap load not followed by a shift cycle");

  a_done_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && (!out_valid || out_ready) |=> out_valid && in_ready)
    else $error("finished sum not presented at the output");

endmodule

// ----- rtl/core/pcff_ram.sv -----
// generic single-write, single-read ram with registered read data
module pcff_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/pcff_tap_mac.sv -----
// bit-serial tap unit: walks the power mask one bit per step cycle into a 40-bit sum
module pcff_tap_mac import pcff_pkg::*; #(
  parameter int POWERS = POWERS_DEF
) (
  input  logic                       clk,
  input  mac_ctl_t                   ctl,
  input  logic signed [SAMPLE_W-1:0] x,
  input  logic [COEFF_W-1:0]         coeff,
  output logic signed [ACC_W-1:0]    acc
);

  localparam int SKIP = SAMPLE_W - POWERS;  // powers below the used range
  localparam int XW   = 2 * SAMPLE_W;

  logic signed [XW-1:0]    xsh;
  logic [POWERS-1:0]       mag;
  logic [POWERS-1:0]       sgn;
  logic signed [ACC_W-1:0] term;

  assign term = {{(ACC_W - XW){xsh[XW-1]}}, xsh};

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.step && mag[0]) begin
      acc <= sgn[0] ? acc - term : acc + term;
    end

    if (ctl.load) begin
      // lowest used power first: x << (16 - POWERS)
      xsh <= {{SAMPLE_W{x[SAMPLE_W-1]}}, x} <<< SKIP;
      mag <= coeff[SAMPLE_W-1 -: POWERS];
      sgn <= coeff[COEFF_W-1 -: POWERS];
    end else if (ctl.step) begin
      xsh <= xsh <<< 1;
      mag <= mag >> 1;
      sgn <= sgn >> 1;
    end
  end

endmodule

// ----- test/pot_coefficient_fir_filter_top_test.sv -----
// testbench for the power-of-two coefficient fir filter top level
module pot_coefficient_fir_filter_top_test import pcff_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // stimulus size: the full coefficient fill, the directed words, then random words
  localparam int N_WORDS    = 1450;
  localparam int N_DIRECTED = 16;
  localparam int N_RANDOM   = N_WORDS - TAPS_DEF - N_DIRECTED;

  // wait a little longer than one sample takes to sweep all taps
  localparam int DRAIN_CYCLES = 4400;

  // keeps its own copy of the coefficients and the sample history and the
  // queue of filter sums still owed by the block
  class fir_scoreboard;
    logic [COEFF_W-1:0]         coeffs [TAPS_DEF];
    logic signed [SAMPLE_W-1:0] history [TAPS_DEF];
    logic signed [ACC_W-1:0]    sums_due [$];
    int                         errors;
    int                         results_seen;

    function new();
      foreach (coeffs[k]) coeffs[k] = '0;
      foreach (history[k]) history[k] = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    // sum over all taps of +/- (x << 16) >> j for every selected power j
    function logic signed [ACC_W-1:0] pot_fir_sum();
      longint acc;
      longint term;
      acc = 0;
      for (int k = 0; k < TAPS_DEF; k++) begin
        for (int j = 1; j <= POWERS_DEF; j++) begin
          // power mask bit 16-j picks 2^-j, sign bit 32-j negates it
          if (coeffs[k][16-j]) begin
            term = longint'(history[k]) * (longint'(1) << (16 - j));
            acc = coeffs[k][32-j] ? acc - term : acc + term;
          end
        end
      end
      return acc[ACC_W-1:0];
    endfunction

    function void note_word(logic m, logic [INDEX_W-1:0] idx, logic [COEFF_W-1:0] cw,
                            logic signed [SAMPLE_W-1:0] s);
      if (m == MODE_LOAD) begin
        if (int'(idx) < TAPS_DEF) coeffs[idx] = cw;
      end else begin
        for (int k = TAPS_DEF - 1; k > 0; k--) history[k] = history[k-1];
        history[0] = s;
        sums_due.push_back(pot_fir_sum());
      end
    endfunction

    function void check_result(logic signed [ACC_W-1:0] got);
      logic signed [ACC_W-1:0] want;
      results_seen++;
      if (sums_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: filtered_out %0d arrived with no sample pending",
                   results_seen, got);
        return;
      end
      want = sums_due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: filtered_out expected %0d (0x%h) got %0d (0x%h)",
                   results_seen, want, want, got, got);
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic                       mode;
  logic [INDEX_W-1:0]         tap_index;
  logic [COEFF_W-1:0]         coeff_word;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [ACC_W-1:0]    filtered_out;

  fir_scoreboard sb;
  int            burst_left;

  pot_coefficient_fir_filter_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .tap_index    (tap_index),
    .coeff_word   (coeff_word),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .filtered_out (filtered_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // coefficient words: full masks of either sign, a single power, or anything
  function automatic logic [COEFF_W-1:0] pick_coeff();
    int p;
    p = $urandom_range(0, 15);
    case ($urandom_range(0, 7))
      0: return 32'h0000_FFFF;
      1: return 32'hFFFF_FFFF;
      2: return ($urandom & (32'h0001_0000 << p)) | (32'h1 << p);
      3: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // one word through the input handshake; the sender runs in bursts, and
  // between bursts valid drops for a short or sometimes a very long gap so
  // that new words land on every phase of a sample's tap sweep
  task automatic send_word(input logic m, input logic [INDEX_W-1:0] idx,
                           input logic [COEFF_W-1:0] cw,
                           input logic signed [SAMPLE_W-1:0] s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 4400) : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid   <= 1'b0;
        // junk on the payload while nothing is offered
        mode       <= 1'($urandom);
        tap_index  <= INDEX_W'($urandom);
        coeff_word <= $urandom;
        sample     <= SAMPLE_W'($urandom);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 12);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    mode       <= m;
    tap_index  <= idx;
    coeff_word <= cw;
    sample     <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_word(m, idx, cw, s);
    burst_left--;
  endtask

  // hold off the sender until every owed sum has come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.sums_due.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  initial begin : stimulus
    logic signed [SAMPLE_W-1:0] s;
    logic signed [SAMPLE_W-1:0] run_val;
    int                         run_left;
    sb         = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    mode       = MODE_LOAD;
    tap_index  = '0;
    coeff_word = '0;
    sample     = '0;
    burst_left = 0;
    run_left   = 0;
    run_val    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every slot is read on each sample, so all of them get written first
    for (int k = 0; k < TAPS_DEF; k++)
      send_word(MODE_LOAD, INDEX_W'(k), pick_coeff(), SAMPLE_W'($urandom));

    // directed coefficients: all powers negated, all powers positive,
    // signs with no powers (no contribution), the largest and the smallest
    // power negated, and the highest slot
    send_word(MODE_LOAD, 8'd0,   32'hFFFF_FFFF, 16'sd0);
    send_word(MODE_LOAD, 8'd1,   32'h0000_FFFF, 16'sd0);
    send_word(MODE_LOAD, 8'd2,   32'hFFFF_0000, 16'sd0);
    send_word(MODE_LOAD, 8'd3,   32'h8000_8000, 16'sd0);
    send_word(MODE_LOAD, 8'd4,   32'h0001_0001, 16'sd0);
    send_word(MODE_LOAD, 8'd255, 32'h0000_FFFF, 16'sd0);

    // directed samples: both extremes, around zero, negative samples
    // under positive and negated taps
    send_word(MODE_FILTER, 8'd0, 32'h0, 16'sh7FFF);
    send_word(MODE_FILTER, 8'd0, 32'h0, -16'sh8000);
    send_word(MODE_FILTER, 8'd0, 32'h0, -16'sd1);
    send_word(MODE_FILTER, 8'd0, 32'h0, 16'sd0);
    send_word(MODE_FILTER, 8'd0, 32'h0, 16'sd1);
    send_word(MODE_FILTER, 8'd0, 32'h0, -16'sh8000);
    send_word(MODE_FILTER, 8'd0, 32'h0, 16'sh7FFF);
    send_word(MODE_FILTER, 8'd0, 32'h0, -16'sh8000);

    // rewrite a slot between samples, newest tap now contributes nothing
    send_word(MODE_LOAD, 8'd0, 32'h0000_0000, 16'sd0);
    send_word(MODE_FILTER, 8'd0, 32'h0, -16'sh8000);

    // let the block empty out once before the random part
    wait_drained();

    // random part: roughly one sample per three loads; runs of an extreme
    // sample build up large sums across the history
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) wait_drained();
      if ($urandom_range(0, 3) == 0) begin
        if (run_left > 0) begin
          s = run_val;
          run_left--;
        end else begin
          case ($urandom_range(0, 9))
            0: begin
              run_val  = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
              run_left = $urandom_range(4, 20);
              s        = run_val;
            end
            1: s = -16'sh8000;
            2: s = 16'sh7FFF;
            3: s = $urandom_range(0, 1) ? -16'sd1 : 16'sd0;
            default: s = SAMPLE_W'($urandom);
          endcase
        end
        send_word(MODE_FILTER, INDEX_W'($urandom), $urandom, s);
      end else begin
        send_word(MODE_LOAD, INDEX_W'($urandom), pick_coeff(), SAMPLE_W'($urandom));
      end
    end

    wait_drained();
    // watch a while longer for any stray output
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.sums_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // receiver: windows of always ready, random ready, sparse ready, or a
  // long stall that can outlast a whole sample so the input side backs up
  initial begin : receiver
    int style;
    int span;
    out_ready = 1'b0;
    forever begin
      style = $urandom_range(0, 9);
      span  = (style >= 8) ? $urandom_range(1000, 9000) : $urandom_range(200, 2000);
      repeat (span) begin
        @(negedge clk);
        case (style)
          0, 1, 2, 3: out_ready <= 1'b1;
          4, 5, 6:    out_ready <= 1'($urandom);
          7:          out_ready <= ($urandom_range(0, 7) == 0);
          default:    out_ready <= 1'b0;
        endcase
      end
    end
  end

  // every accepted output word is checked against the oldest owed sum
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(filtered_out);
  end

  // the slowest correct run, every word a sample plus the longest sender gap
  // and receiver stall each time, ends well within this timeout
  initial begin : watchdog
    #500ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- pot_coefficient_fir_filter_top.f -----
rtl/core/pcff_pkg.sv
rtl/core/pcff_ram.sv
rtl/core/pcff_tap_mac.sv
rtl/core/pot_coefficient_fir_filter_top.sv
test/pot_coefficient_fir_filter_top_test.sv
